// File: sv/lkvc_pkg.sv
package lkvc_pkg;

	localparam int ENTRIES  = 16;
	localparam int KEY_BITS = 16;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int AGE_W = IDX_W;
	localparam int KEY_PORT_W = 16;
	localparam int KEY_W = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET  = CAP_W'(16);
	localparam logic [VAL_W-1:0] MISS_VALUE = '1;

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             active;
		logic             all;
		logic [AGE_W-1:0] thr;
		logic [IDX_W-1:0] slot;
	} pend_t;

	typedef struct packed {
		logic             match_found;
		logic [IDX_W-1:0] match_idx;
		logic [AGE_W-1:0] match_age;
		logic [VAL_W-1:0] match_val;
		logic             free_found;
		logic [IDX_W-1:0] free_idx;
		logic             old_found;
		logic [IDX_W-1:0] old_idx;
		logic [AGE_W-1:0] old_age;
	} scan_res_t;

	function automatic logic [CNT_W-1:0] effective_cap(input logic [CAP_W-1:0] c);
		logic [CNT_W-1:0] r;
		if (c == '0) begin
			r = CNT_W'(1);
		end else if (int'(c) > ENTRIES) begin
			r = CNT_W'(ENTRIES);
		end else begin
			r = CNT_W'(c);
		end
		return r;
	endfunction

endpackage

// File: sv/lkvc_ram.sv
module lkvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: sv/lkvc_scan.sv
module lkvc_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      en,
	input  logic [lkvc_pkg::IDX_W-1:0] idx,
	input  logic                      ent_valid,
	input  logic [lkvc_pkg::KEY_W-1:0] key,
	input  logic [lkvc_pkg::KEY_W-1:0] key_rdata,
	input  logic [lkvc_pkg::VAL_W-1:0] val_rdata,
	input  logic [lkvc_pkg::AGE_W-1:0] age_rdata,
	input  lkvc_pkg::pend_t            pend,
	output logic [lkvc_pkg::AGE_W-1:0] age_upd,
	output lkvc_pkg::scan_res_t        res
);
	import lkvc_pkg::*;

	scan_res_t res_q;

	// apply the recency update left by the previous request
	always_comb begin
		age_upd = age_rdata;
		if (ent_valid && pend.active && idx != pend.slot &&
		    (pend.all || age_rdata < pend.thr)) begin
			age_upd = age_rdata + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (clear) begin
			res_q.match_found <= 1'b0;
			res_q.free_found  <= 1'b0;
			res_q.old_found   <= 1'b0;
		end else if (en) begin
			if (ent_valid && key_rdata == key && !res_q.match_found) begin
				res_q.match_found <= 1'b1;
				res_q.match_idx   <= idx;
				res_q.match_age   <= age_upd;
				res_q.match_val   <= val_rdata;
			end
			if (!ent_valid && !res_q.free_found) begin
				res_q.free_found <= 1'b1;
				res_q.free_idx   <= idx;
			end
			if (ent_valid && (!res_q.old_found || age_upd > res_q.old_age)) begin
				res_q.old_found <= 1'b1;
				res_q.old_idx   <= idx;
				res_q.old_age   <= age_upd;
			end
		end
	end

	assign res = res_q;

endmodule

// File: sv/lru_key_value_cache_unit.sv
// channel | direction | handshake              | payload
// cfg     | in        | cfg_valid / cfg_ready  | cfg_data (capacity)
// in      | in        | in_valid / in_ready    | kind, lookup_key, store_value
// out     | out       | out_valid / out_ready  | hit, read_value, evicted
//
// A request walks all 16 entries: each RAM read is registered and folded into the
// scan result, and the final step registers the result in the output register.
// A new request is accepted only after that final step, so requests never overlap.
// Ages are brought up to date during the following request's walk.
// Reset clears the valid bits, occupancy and capacity (16) at once; no clearing pass.
// A result waits in the output register; the block holds its last step until taken.
// Configuration is always ready.
module lru_key_value_cache_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lkvc_pkg::CAP_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        kind,
	input  logic [lkvc_pkg::KEY_PORT_W-1:0] lookup_key,
	input  logic signed [lkvc_pkg::VAL_W-1:0] store_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        hit,
	output logic signed [lkvc_pkg::VAL_W-1:0] read_value,
	output logic                        evicted
);
	import lkvc_pkg::*;

	state_t state_q, state_d;

	logic [CAP_W-1:0] cap_q;
	logic [CNT_W-1:0] occ_q;
	logic [ENTRIES-1:0] valid_q;
	pend_t pend_q;

	logic             kind_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	logic [CNT_W-1:0] idx_q;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic             out_valid_q;
	logic             hit_q;
	logic [VAL_W-1:0] rd_q;
	logic             ev_q;

	logic [KEY_W-1:0] key_rdata;
	logic [VAL_W-1:0] val_rdata;
	logic [AGE_W-1:0] age_rdata;
	logic [AGE_W-1:0] age_upd;
	scan_res_t        res;

	logic accept, issue, scan_last, finish;
	logic full, do_evict, ins_ok;
	logic [IDX_W-1:0] ins_slot;

	logic             age_we, key_we, val_we;
	logic [IDX_W-1:0] age_waddr, val_waddr;
	logic [AGE_W-1:0] age_wdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign issue     = (state_q == ST_SCAN) && (idx_q < CNT_W'(ENTRIES));
	assign scan_last = rd_valid_s1 && (rd_idx_s1 == IDX_W'(ENTRIES - 1));
	assign finish    = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign full     = occ_q >= effective_cap(cap_q);
	assign do_evict = (kind_q == KIND_PUT) && !res.match_found && full && res.old_found;
	assign ins_slot = do_evict ? res.old_idx : res.free_idx;
	assign ins_ok   = (kind_q == KIND_PUT) && !res.match_found && (do_evict || res.free_found);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (finish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			key_q  <= lookup_key[KEY_W-1:0];
			val_q  <= store_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else begin
			rd_valid_s1 <= issue;
			rd_idx_s1   <= idx_q[IDX_W-1:0];
			if (accept) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			pend_q  <= '0;
		end else if (finish) begin
			pend_q.active <= 1'b0;
			if (res.match_found) begin
				pend_q.active <= 1'b1;
				pend_q.all    <= 1'b0;
				pend_q.thr    <= res.match_age;
				pend_q.slot   <= res.match_idx;
			end else if (ins_ok) begin
				pend_q.active     <= 1'b1;
				pend_q.all        <= 1'b1;
				pend_q.thr        <= '0;
				pend_q.slot       <= ins_slot;
				valid_q[ins_slot] <= 1'b1;
				if (!do_evict) begin
					occ_q <= occ_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			hit_q <= res.match_found;
			rd_q  <= (res.match_found && kind_q == KIND_GET) ? res.match_val : MISS_VALUE;
			ev_q  <= do_evict;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = rd_q;
	assign evicted    = ev_q;

	// write back aged entries during the walk, then the touched slot
	always_comb begin
		age_we    = 1'b0;
		age_waddr = rd_idx_s1;
		age_wdata = age_upd;
		key_we    = finish && ins_ok;
		val_we    = 1'b0;
		val_waddr = ins_slot;
		if (rd_valid_s1) begin
			age_we = 1'b1;
		end else if (finish && (res.match_found || ins_ok)) begin
			age_we    = 1'b1;
			age_waddr = res.match_found ? res.match_idx : ins_slot;
			age_wdata = '0;
		end
		if (finish && kind_q == KIND_PUT && (res.match_found || ins_ok)) begin
			val_we    = 1'b1;
			val_waddr = res.match_found ? res.match_idx : ins_slot;
		end
	end

	lkvc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (ins_slot),
		.wdata (key_q),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (key_rdata)
	);

	lkvc_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (val_q),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (val_rdata)
	);

	lkvc_ram #(.WIDTH(AGE_W), .DEPTH(ENTRIES)) u_age_ram (
		.clk   (clk),
		.we    (age_we),
		.waddr (age_waddr),
		.wdata (age_wdata),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (age_rdata)
	);

	lkvc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept),
		.en        (rd_valid_s1),
		.idx       (rd_idx_s1),
		.ent_valid (valid_q[rd_idx_s1]),
		.key       (key_q),
		.key_rdata (key_rdata),
		.val_rdata (val_rdata),
		.age_rdata (age_rdata),
		.pend      (pend_q),
		.age_upd   (age_upd),
		.res       (res)
	);

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy disagrees with valid bits");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= ENTRIES)
		else $error("occupancy above entry count");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside final step");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN && idx_q == '0))
		else $error("accepted request did not start a walk");

endmodule

// File: tb/lru_key_value_cache_unit_tb.sv
module lru_key_value_cache_unit_tb;

	import lkvc_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 300;
	localparam int SETTLE     = 25;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] read_value;
		logic             evicted;
	} cache_reply_t;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CAP_W-1:0]      cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic                  kind        = KIND_GET;
	logic [KEY_PORT_W-1:0] lookup_key  = '0;
	logic signed [VAL_W-1:0] store_value = '0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic                  hit;
	logic signed [VAL_W-1:0] read_value;
	logic                  evicted;

	cache_reply_t expected_replies [$];
	int           mismatch_count = 0;
	bit           idle_on        = 1'b1;
	bit           hold_results   = 1'b0;

	logic [ENTRIES-1:0]    model_valid = '0;
	logic [KEY_PORT_W-1:0] model_key   [ENTRIES];
	logic [VAL_W-1:0]      model_value [ENTRIES];
	int unsigned           model_age   [ENTRIES];
	int unsigned           model_fill  = 0;
	logic [CAP_W-1:0]      model_cap   = CAP_RESET;

	lru_key_value_cache_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.lookup_key  (lookup_key),
		.store_value (store_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted)
	);

	always #1 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned usable_capacity(input logic [CAP_W-1:0] c);
		if (c == '0) begin
			return 1;
		end else if (int'(c) > ENTRIES) begin
			return ENTRIES;
		end
		return int'(c);
	endfunction

	function automatic cache_reply_t predict_reply(input logic op,
			input logic [KEY_PORT_W-1:0] key, input logic [VAL_W-1:0] data);
		cache_reply_t r;
		int           found;
		int           victim;
		int unsigned  oldest;
		int unsigned  a;
		int           i;
		r.hit        = 1'b0;
		r.read_value = MISS_VALUE;
		r.evicted    = 1'b0;
		found        = -1;
		for (i = 0; i < ENTRIES; i++) begin
			if (found < 0 && model_valid[i] && model_key[i] == key) begin
				found = i;
			end
		end
		if (found >= 0) begin
			r.hit = 1'b1;
			if (op == KIND_GET) begin
				r.read_value = model_value[found];
			end else begin
				model_value[found] = data;
			end
			a = model_age[found];
			for (i = 0; i < ENTRIES; i++) begin
				if (model_valid[i] && model_age[i] < a) begin
					model_age[i]++;
				end
			end
			model_age[found] = 0;
		end else if (op == KIND_PUT) begin
			victim = -1;
			oldest = 0;
			if (model_fill >= usable_capacity(model_cap) || model_fill >= ENTRIES) begin
				for (i = 0; i < ENTRIES; i++) begin
					if (model_valid[i] && (victim < 0 || model_age[i] > oldest)) begin
						victim = i;
						oldest = model_age[i];
					end
				end
				if (victim >= 0) begin
					model_valid[victim] = 1'b0;
					model_fill--;
					r.evicted = 1'b1;
				end
			end
			if (victim < 0) begin
				for (i = ENTRIES - 1; i >= 0; i--) begin
					if (!model_valid[i]) begin
						victim = i;
					end
				end
			end
			if (victim >= 0) begin
				for (i = 0; i < ENTRIES; i++) begin
					if (model_valid[i]) begin
						model_age[i]++;
					end
				end
				model_valid[victim] = 1'b1;
				model_key[victim]   = key;
				model_value[victim] = data;
				model_age[victim]   = 0;
				model_fill++;
			end
		end
		return r;
	endfunction

	task automatic send_request(input logic op, input logic [KEY_PORT_W-1:0] key,
			input logic [VAL_W-1:0] data);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= op;
		lookup_key  <= key;
		store_value <= data;
		@(negedge clk);
		while (!in_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		expected_replies.push_back(predict_reply(op, key, data));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(negedge clk);
		while (!cfg_ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		model_cap = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_basic_lookup();
		send_request(KIND_GET, 16'h0000, 32'h0000_0000);
		send_request(KIND_GET, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(KIND_PUT, 16'h0000, 32'h7FFF_FFFF);
		send_request(KIND_PUT, 16'hFFFF, 32'h8000_0000);
		send_request(KIND_GET, 16'h0000, 32'h0000_0000);
		send_request(KIND_GET, 16'hFFFF, 32'h0000_0000);
		send_request(KIND_PUT, 16'h0000, 32'hFFFF_FFFF);
		send_request(KIND_GET, 16'h0000, 32'h5555_5555);
	endtask

	task automatic test_capacity_limits();
		write_capacity(CAP_W'(1));
		send_request(KIND_PUT, 16'h1234, 32'h0000_0005);
		send_request(KIND_GET, 16'h1234, 32'h0000_0000);
		send_request(KIND_PUT, 16'h5678, 32'hAAAA_AAAA);
		send_request(KIND_GET, 16'h0000, 32'h0000_0000);
		write_capacity(CAP_W'(0));
		send_request(KIND_PUT, 16'h0001, 32'h1234_5678);
		send_request(KIND_GET, 16'h0001, 32'h0000_0000);
		write_capacity(CAP_W'(31));
		send_request(KIND_PUT, 16'h8000, 32'h0000_0001);
		send_request(KIND_PUT, 16'h7FFF, 32'hFFFF_FFFE);
		send_request(KIND_PUT, 16'h00FF, 32'h0F0F_0F0F);
		send_request(KIND_GET, 16'h8000, 32'h0000_0000);
		send_request(KIND_GET, 16'h5678, 32'h0000_0000);
	endtask

	task automatic test_output_stall();
		int n;
		drain();
		idle_on      = 1'b0;
		hold_results = 1'b1;
		for (n = 0; n < 24; n++) begin
			send_request(($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET,
				KEY_PORT_W'($urandom_range(0, 7)), $urandom());
		end
		drain();
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [KEY_PORT_W-1:0] key_pool [20];
		logic [CAP_W-1:0]      cap;
		int unsigned           pool_size;
		int unsigned           r;
		int                    phase;
		int                    n;
		int                    j;
		for (phase = 0; phase < 9; phase++) begin
			case (phase)
				0: cap = CAP_W'(1);
				1: cap = CAP_W'(2);
				2: cap = CAP_W'(3);
				3: cap = CAP_W'(5);
				4: cap = CAP_W'(8);
				5: cap = CAP_W'(16);
				6: cap = CAP_W'(0);
				7: cap = CAP_W'(31);
				default: cap = CAP_W'($urandom_range(0, 31));
			endcase
			write_capacity(cap);
			pool_size = usable_capacity(cap) + 3;
			for (j = 0; j < int'(pool_size); j++) begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					key_pool[j] = '0;
				end else if (r == 1) begin
					key_pool[j] = '1;
				end else begin
					key_pool[j] = KEY_PORT_W'($urandom_range(0, 65535));
				end
			end
			for (n = 0; n < 72; n++) begin
				if (n % 40 == 39) begin
					idle_on = ($urandom_range(0, 3) != 0);
				end
				if ($urandom_range(0, 4) == 0) begin
					send_request(($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET,
						KEY_PORT_W'($urandom_range(0, 65535)), $urandom());
				end else begin
					send_request(($urandom_range(0, 1) == 1) ? KIND_PUT : KIND_GET,
						key_pool[$urandom_range(0, pool_size - 1)], $urandom());
				end
			end
			idle_on = 1'b1;
		end
	endtask

	initial begin
		int unsigned gap;
		forever begin
			@(posedge clk);
			gap = pick_gap();
			if (hold_results) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_results = 1'b0;
				out_ready <= 1'b1;
			end else if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(negedge clk) begin
		cache_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected result: hit %0d, read_value %0d, evicted %0d",
					hit, read_value, evicted);
				mismatch_count++;
			end else begin
				want = expected_replies.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, actual %0d", want.hit, hit);
					mismatch_count++;
				end
				if (read_value !== want.read_value) begin
					$error("read_value: expected %0d, actual %0d",
						$signed(want.read_value), read_value);
					mismatch_count++;
				end
				if (evicted !== want.evicted) begin
					$error("evicted: expected %0d, actual %0d", want.evicted, evicted);
					mismatch_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(negedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_lookup();
		test_capacity_limits();
		test_output_stall();
		test_random_traffic();
		write_capacity(CAP_RESET);
		send_request(KIND_GET, 16'h0000, 32'h0000_0000);
		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_count == 0 && expected_replies.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
sv/lkvc_pkg.sv
sv/lkvc_ram.sv
sv/lkvc_scan.sv
sv/lru_key_value_cache_unit.sv
tb/lru_key_value_cache_unit_tb.sv
